FILE: src/steq_pkg.sv
// Shared types and constants for the sorted timer event queue.
package steq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_W            = 16;
    localparam int TIME_W          = 32;
    localparam int REM_W           = 5;
    localparam logic [REM_W-1:0] REM_MAX = '1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_POLL   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOT_DUE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_READ,
        S_EVAL,
        S_HEAD,
        S_FIN
    } t_state;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_READ,
        DP_SET_FULL,
        DP_SET_NOT_DUE,
        DP_INS_START,
        DP_INS_SHIFT,
        DP_INS_PLACE,
        DP_INS_HEAD,
        DP_REM_STEP,
        DP_REM_END,
        DP_POP_HEAD,
        DP_POP_LAST,
        DP_POP_SHIFT,
        DP_POP_SHIFT_END,
        DP_PUBLISH
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic empty;
        logic at_zero;
        logic at_last;
        logic hit;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: src/sorted_timer_event_queue.sv
// An insert into a full or empty queue, a remove or poll of an empty queue or an unused opcode
// finishes without a scan; otherwise the scan reads one entry from the single-port queue memory
// in S_READ and acts on it in S_EVAL, for at most QUEUE_DEPTH entries.
// Throughput: one beat at a time; the next beat is taken once the result sits in the output
// register, so a waiting result does not block the next operation until it finishes.
// Reset: synchronous, active low; empties the queue and drops any pending result beat.
module sorted_timer_event_queue import steq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_opcode,
    input  logic [ID_W-1:0]   i_event_id,
    input  logic [TIME_W-1:0] i_due_time,
    input  logic [TIME_W-1:0] i_now_time,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic [REM_W-1:0]  o_removed_count,
    output logic [ID_W-1:0]   o_popped_id,
    output logic [TIME_W-1:0] o_popped_due
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    steq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Storage and result path
    steq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_opcode        (i_opcode),
        .i_event_id      (i_event_id),
        .i_due_time      (i_due_time),
        .i_now_time      (i_now_time),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_removed_count (o_removed_count),
        .o_popped_id     (o_popped_id),
        .o_popped_due    (o_popped_due)
    );

endmodule

FILE: src/steq_ctrl.sv
// Sequencer that steps the queue datapath through insert, remove and poll.
module steq_ctrl import steq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.op)
                    OP_INSERT: n_state = (i_stat.full || i_stat.empty) ? S_FIN : S_READ;
                    OP_REMOVE: n_state = i_stat.empty ? S_FIN : S_READ;
                    OP_POLL:   n_state = i_stat.empty ? S_FIN : S_READ;
                    default:   n_state = S_FIN;
                endcase
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                case (i_stat.op)
                    OP_INSERT: begin
                        if (!i_stat.hit) begin
                            n_state = S_FIN;
                        end else if (i_stat.at_zero) begin
                            n_state = S_HEAD;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                    OP_REMOVE: n_state = i_stat.at_last ? S_FIN : S_READ;
                    OP_POLL: begin
                        if (i_stat.at_zero && i_stat.hit) begin
                            n_state = S_FIN;
                        end else begin
                            n_state = i_stat.at_last ? S_FIN : S_READ;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_HEAD: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd   = DP_NONE;
        o_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd = DP_LOAD;
                end
            end
            S_DISP: begin
                case (i_stat.op)
                    OP_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd = DP_SET_FULL;
                        end else if (i_stat.empty) begin
                            o_cmd = DP_INS_HEAD;
                        end else begin
                            o_cmd = DP_INS_START;
                        end
                    end
                    OP_POLL: begin
                        if (i_stat.empty) begin
                            o_cmd = DP_SET_NOT_DUE;
                        end
                    end
                    default: o_cmd = DP_NONE;
                endcase
            end
            S_READ: begin
                o_cmd = DP_READ;
            end
            S_EVAL: begin
                case (i_stat.op)
                    OP_INSERT: o_cmd = i_stat.hit ? DP_INS_SHIFT : DP_INS_PLACE;
                    OP_REMOVE: o_cmd = i_stat.at_last ? DP_REM_END : DP_REM_STEP;
                    OP_POLL: begin
                        if (i_stat.at_zero) begin
                            if (i_stat.hit) begin
                                o_cmd = DP_SET_NOT_DUE;
                            end else begin
                                o_cmd = i_stat.at_last ? DP_POP_LAST : DP_POP_HEAD;
                            end
                        end else begin
                            o_cmd = i_stat.at_last ? DP_POP_SHIFT_END : DP_POP_SHIFT;
                        end
                    end
                    default: o_cmd = DP_NONE;
                endcase
            end
            S_HEAD: begin
                o_cmd = DP_INS_HEAD;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd = DP_PUBLISH;
                end
            end
            default: o_cmd = DP_NONE;
        endcase
    end

endmodule

FILE: src/steq_dpath.sv
// Queue storage, scan index, compare logic and result register.
module steq_dpath import steq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [1:0]        i_opcode,
    input  logic [ID_W-1:0]   i_event_id,
    input  logic [TIME_W-1:0] i_due_time,
    input  logic [TIME_W-1:0] i_now_time,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic [REM_W-1:0]  o_removed_count,
    output logic [ID_W-1:0]   o_popped_id,
    output logic [TIME_W-1:0] o_popped_due
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Storage
    logic [ID_W-1:0]   r_mem_id   [QUEUE_DEPTH];
    logic [TIME_W-1:0] r_mem_time [QUEUE_DEPTH];
    logic [ID_W-1:0]   r_rd_id;
    logic [TIME_W-1:0] r_rd_time;

    // Item and scan state
    t_op               r_op;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_due;
    logic [TIME_W-1:0] r_now;
    logic [AW-1:0]     r_idx;
    logic [CW-1:0]     r_kept;
    logic [CW-1:0]     r_count;

    // Working result and output beat
    t_status           r_res_status;
    logic [REM_W-1:0]  r_removed;
    logic [ID_W-1:0]   r_pid;
    logic [TIME_W-1:0] r_pdue;
    logic              r_out_valid;
    logic [1:0]        r_o_status;
    logic [REM_W-1:0]  r_o_removed;
    logic [ID_W-1:0]   r_o_pid;
    logic [TIME_W-1:0] r_o_pdue;

    logic              hit;
    logic [CW-1:0]     count_m1;
    logic [CW-1:0]     kept_next;
    logic [REM_W-1:0]  removed_next;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [ID_W-1:0]   wr_id;
    logic [TIME_W-1:0] wr_time;

    // Compare the entry just read against the item
    always_comb begin
        case (r_op)
            OP_INSERT: hit = (r_rd_time > r_due);
            OP_REMOVE: hit = (r_rd_id == r_id);
            OP_POLL:   hit = (r_rd_time > r_now);
            default:   hit = 1'b0;
        endcase
    end

    assign count_m1     = r_count - CW'(1);
    assign kept_next    = r_kept + CW'(!hit);
    assign removed_next = (hit && (r_removed != REM_MAX)) ? r_removed + REM_W'(1) : r_removed;

    // Status to the sequencer
    always_comb begin
        o_stat.op       = r_op;
        o_stat.full     = (r_count == CW'(QUEUE_DEPTH));
        o_stat.empty    = (r_count == '0);
        o_stat.at_zero  = (r_idx == '0);
        o_stat.at_last  = (CW'(r_idx) == count_m1);
        o_stat.hit      = hit;
        o_stat.out_free = !r_out_valid || !i_stall;
    end

    // Select the write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_id   = r_rd_id;
        wr_time = r_rd_time;
        case (i_cmd)
            DP_INS_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_idx + AW'(1);
            end
            DP_INS_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = r_idx + AW'(1);
                wr_id   = r_id;
                wr_time = r_due;
            end
            DP_INS_HEAD: begin
                wr_en   = 1'b1;
                wr_id   = r_id;
                wr_time = r_due;
            end
            DP_REM_STEP, DP_REM_END: begin
                wr_en   = !hit;
                wr_addr = r_kept[AW-1:0];
            end
            DP_POP_SHIFT, DP_POP_SHIFT_END: begin
                wr_en   = 1'b1;
                wr_addr = r_idx - AW'(1);
            end
            default: wr_en = 1'b0;
        endcase
    end

    // Write and read the memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_id[wr_addr]   <= wr_id;
            r_mem_time[wr_addr] <= wr_time;
        end
        if (i_cmd == DP_READ) begin
            r_rd_id   <= r_mem_id[r_idx];
            r_rd_time <= r_mem_time[r_idx];
        end
    end

    // Track the fill level and the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd)
                DP_INS_PLACE, DP_INS_HEAD:       r_count <= r_count + CW'(1);
                DP_REM_END:                      r_count <= kept_next;
                DP_POP_LAST, DP_POP_SHIFT_END:   r_count <= count_m1;
                default:                         r_count <= r_count;
            endcase
            if (i_cmd == DP_PUBLISH) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the item, advance the scan and build the result
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_LOAD: begin
                r_op         <= t_op'(i_opcode);
                r_id         <= i_event_id;
                r_due        <= i_due_time;
                r_now        <= i_now_time;
                r_idx        <= '0;
                r_kept       <= '0;
                r_removed    <= '0;
                r_res_status <= ST_DONE;
                r_pid        <= '0;
                r_pdue       <= '0;
            end
            DP_SET_FULL:    r_res_status <= ST_FULL;
            DP_SET_NOT_DUE: r_res_status <= ST_NOT_DUE;
            DP_INS_START:   r_idx        <= count_m1[AW-1:0];
            DP_INS_SHIFT:   r_idx        <= r_idx - AW'(1);
            DP_REM_STEP: begin
                r_kept    <= kept_next;
                r_removed <= removed_next;
                r_idx     <= r_idx + AW'(1);
            end
            DP_REM_END: begin
                r_removed <= removed_next;
            end
            DP_POP_HEAD: begin
                r_pid  <= r_rd_id;
                r_pdue <= r_rd_time;
                r_idx  <= r_idx + AW'(1);
            end
            DP_POP_LAST: begin
                r_pid  <= r_rd_id;
                r_pdue <= r_rd_time;
            end
            DP_POP_SHIFT:   r_idx <= r_idx + AW'(1);
            DP_PUBLISH: begin
                r_o_status  <= r_res_status;
                r_o_removed <= r_removed;
                r_o_pid     <= r_pid;
                r_o_pdue    <= r_pdue;
            end
            default: r_idx <= r_idx;
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_o_status;
    assign o_removed_count = r_o_removed;
    assign o_popped_id     = r_o_pid;
    assign o_popped_due    = r_o_pdue;

endmodule

FILE: tb/tb_sorted_timer_event_queue.sv
// Self-checking testbench for the sorted timer event queue.
`timescale 1ns / 100ps

module tb_sorted_timer_event_queue;
    import steq_pkg::*;

    localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
    localparam int RANDOM_OPS  = 1800;
    localparam int SETTLE_CYC  = 2 * QUEUE_DEPTH + 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int POOL_N      = 6;

    typedef struct packed {
        t_op               op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] due_time;
        logic [TIME_W-1:0] now_time;
        logic              drain_first;
    } t_beat;

    typedef struct packed {
        t_status           status;
        logic [REM_W-1:0]  removed;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] due;
    } t_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [1:0]        i_opcode = OP_NONE;
    logic [ID_W-1:0]   i_event_id = '0;
    logic [TIME_W-1:0] i_due_time = '0;
    logic [TIME_W-1:0] i_now_time = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [1:0]        o_status;
    logic [REM_W-1:0]  o_removed_count;
    logic [ID_W-1:0]   o_popped_id;
    logic [TIME_W-1:0] o_popped_due;

    sorted_timer_event_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_event_id     (i_event_id),
        .i_due_time     (i_due_time),
        .i_now_time     (i_now_time),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_removed_count(o_removed_count),
        .o_popped_id    (o_popped_id),
        .o_popped_due   (o_popped_due)
    );

    // Clock
    always #6 i_clk = ~i_clk;

    // Shadow copy of the queue contents
    logic [ID_W-1:0]   shadow_id  [QUEUE_DEPTH];
    logic [TIME_W-1:0] shadow_due [QUEUE_DEPTH];
    int                shadow_cnt = 0;

    t_beat  op_backlog[$];
    t_reply pending_replies[$];

    int errors = 0;
    int cycle_count = 0;
    int n_ops = 0, n_inserts = 0, n_refused = 0, n_removes = 0, n_deleted = 0;
    int most_deleted = 0, n_polls = 0, n_popped = 0, n_unused = 0;

    bit beat_taken = 1'b0, reply_taken = 1'b0, reply_seen = 1'b0;
    bit quiet_in = 1'b0, quiet_out = 1'b0;
    bit send_valid;
    int gap_left = 0, stall_left = 0;
    t_beat next_beat;

    logic [ID_W-1:0]   id_pool [POOL_N];
    logic [TIME_W-1:0] clock_s;

    // Apply one operation to the shadow queue and work out its reply
    function automatic t_reply apply_timer_op(t_op op, logic [ID_W-1:0] id,
                                              logic [TIME_W-1:0] due,
                                              logic [TIME_W-1:0] now);
        t_reply r;
        int     pos;
        int     kept;
        int     gone;
        r = '0;
        r.status = ST_DONE;
        n_ops++;
        case (op)
            OP_INSERT: begin
                n_inserts++;
                if (shadow_cnt >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                    n_refused++;
                end else begin
                    // equal due times keep arrival order
                    pos = 0;
                    while (pos < shadow_cnt && shadow_due[pos] <= due) pos++;
                    for (int i = shadow_cnt; i > pos; i--) begin
                        shadow_id[i]  = shadow_id[i-1];
                        shadow_due[i] = shadow_due[i-1];
                    end
                    shadow_id[pos]  = id;
                    shadow_due[pos] = due;
                    shadow_cnt++;
                end
            end
            OP_REMOVE: begin
                n_removes++;
                kept = 0;
                gone = 0;
                for (int i = 0; i < shadow_cnt; i++) begin
                    if (shadow_id[i] == id) begin
                        gone++;
                    end else begin
                        shadow_id[kept]  = shadow_id[i];
                        shadow_due[kept] = shadow_due[i];
                        kept++;
                    end
                end
                shadow_cnt = kept;
                n_deleted += gone;
                if (gone > most_deleted) most_deleted = gone;
                r.removed = (gone > int'(REM_MAX)) ? REM_MAX : REM_W'(gone);
            end
            OP_POLL: begin
                n_polls++;
                if (shadow_cnt == 0 || shadow_due[0] > now) begin
                    r.status = ST_NOT_DUE;
                end else begin
                    n_popped++;
                    r.id  = shadow_id[0];
                    r.due = shadow_due[0];
                    for (int i = 1; i < shadow_cnt; i++) begin
                        shadow_id[i-1]  = shadow_id[i];
                        shadow_due[i-1] = shadow_due[i];
                    end
                    shadow_cnt--;
                end
            end
            default: n_unused++;
        endcase
        return r;
    endfunction

    task automatic add_beat(t_op op, logic [ID_W-1:0] id, logic [TIME_W-1:0] due,
                            logic [TIME_W-1:0] now, logic hold);
        t_beat b;
        b.op          = op;
        b.id          = id;
        b.due_time    = due;
        b.now_time    = now;
        b.drain_first = hold;
        op_backlog.push_back(b);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        return ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, POOL_N-1)]
                                            : ID_W'($urandom);
    endfunction

    // Due times cluster just ahead of the running clock, with ties and outliers
    function automatic logic [TIME_W-1:0] near_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return clock_s + $urandom_range(0, 60);
        if (r < 88) return clock_s;
        return $urandom;
    endfunction

    function automatic logic [TIME_W-1:0] poll_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return clock_s;
        if (r < 85) return $urandom;
        return (r < 93) ? '1 : '0;
    endfunction

    // Push the queue past capacity, often with a single id
    task automatic fill_burst(logic hold);
        logic [ID_W-1:0] one_id;
        bit              same;
        int              run_len;
        one_id  = pick_id();
        same    = ($urandom_range(0, 1) != 0);
        run_len = $urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 4);
        for (int i = 0; i < run_len; i++)
            add_beat(OP_INSERT, same ? one_id : pick_id(), near_time(), $urandom,
                     hold && i == 0);
        if (same) add_beat(OP_REMOVE, one_id, $urandom, $urandom, 1'b0);
    endtask

    // Stimulus, reset and end of run
    initial begin
        int kind;
        int run_len;
        int r;

        // directed opening: empty queue, unused opcode, ordering, ties, not due
        add_beat(OP_POLL,   '0,              $urandom, '0,            1'b0);
        add_beat(OP_POLL,   '1,              $urandom, '1,            1'b0);
        add_beat(OP_NONE,   '1,              '1,       '1,            1'b0);
        add_beat(OP_REMOVE, '0,              $urandom, $urandom,      1'b0);
        add_beat(OP_INSERT, '0,              '0,       $urandom,      1'b0);
        add_beat(OP_INSERT, '1,              '1,       $urandom,      1'b0);
        add_beat(OP_INSERT, 16'h1234,        32'd100,  $urandom,      1'b0);
        add_beat(OP_INSERT, 16'h5678,        32'd100,  $urandom,      1'b0);
        add_beat(OP_INSERT, 16'h1234,        32'd50,   $urandom,      1'b0);
        add_beat(OP_NONE,   16'h5678,        '0,       '0,            1'b0);
        add_beat(OP_POLL,   ID_W'($urandom), $urandom, '0,            1'b1);
        add_beat(OP_POLL,   ID_W'($urandom), $urandom, 32'd49,        1'b0);
        add_beat(OP_POLL,   ID_W'($urandom), $urandom, 32'd50,        1'b0);
        add_beat(OP_REMOVE, 16'h1234,        $urandom, $urandom,      1'b0);
        add_beat(OP_REMOVE, 16'h9999,        $urandom, $urandom,      1'b0);
        add_beat(OP_POLL,   ID_W'($urandom), $urandom, '1,            1'b0);
        add_beat(OP_POLL,   ID_W'($urandom), $urandom, 32'hFFFF_FFFE, 1'b0);
        add_beat(OP_POLL,   ID_W'($urandom), $urandom, '1,            1'b0);
        add_beat(OP_POLL,   ID_W'($urandom), $urandom, '1,            1'b0);

        for (int i = 0; i < POOL_N; i++) id_pool[i] = ID_W'($urandom);
        id_pool[0] = '0;
        id_pool[1] = '1;
        clock_s = $urandom;

        // random part: mostly coherent runs, some bursts and noise
        fill_burst(1'b1);
        run_len = op_backlog.size() + RANDOM_OPS;
        while (op_backlog.size() < run_len) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                fill_burst($urandom_range(0, 3) == 0);
            end else if (kind == 1) begin
                // drain, the first poll waiting for the queue to go quiet
                r = $urandom_range(QUEUE_DEPTH / 2, QUEUE_DEPTH + 3);
                for (int i = 0; i < r; i++)
                    add_beat(OP_POLL, ID_W'($urandom), $urandom,
                             ($urandom_range(0, 1) != 0) ? '1 : clock_s + 80, i == 0);
            end else if (kind == 2) begin
                for (int i = 0; i < POOL_N; i++)
                    add_beat(OP_REMOVE, id_pool[i], $urandom, $urandom, 1'b0);
            end else begin
                r = $urandom_range(10, 30);
                for (int i = 0; i < r; i++) begin
                    kind = $urandom_range(0, 99);
                    if (kind < 42) begin
                        add_beat(OP_INSERT, pick_id(), near_time(), $urandom, 1'b0);
                    end else if (kind < 55) begin
                        add_beat(OP_REMOVE, pick_id(), $urandom, $urandom, 1'b0);
                    end else if (kind < 95) begin
                        clock_s = clock_s + $urandom_range(0, 20);
                        add_beat(OP_POLL, ID_W'($urandom), $urandom, poll_time(), 1'b0);
                    end else begin
                        add_beat(t_op'($urandom_range(0, 3)), ID_W'($urandom), $urandom,
                                 $urandom, 1'b0);
                    end
                end
            end
        end

        // hold reset, then release it on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (op_backlog.size() != 0 || i_valid) @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Ran %0d operations: %0d inserts (%0d refused when full), %0d removes",
                 n_ops, n_inserts, n_refused, n_removes);
        $display("  deleting %0d events (up to %0d at once), %0d polls popping %0d, %0d unused",
                 n_deleted, most_deleted, n_polls, n_popped, n_unused);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Driver: present beats on the falling edge, with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            send_valid = i_valid;
            if (beat_taken) begin
                beat_taken = 1'b0;
                send_valid = 1'b0;
                gap_left   = quiet_in ? 0 : $urandom_range(0, 4);
                if ($urandom_range(0, 59) == 0) quiet_in = !quiet_in;
            end
            if (!send_valid && op_backlog.size() != 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!op_backlog[0].drain_first || pending_replies.size() == 0) begin
                    next_beat = op_backlog.pop_front();
                    i_opcode   <= next_beat.op;
                    i_event_id <= next_beat.id;
                    i_due_time <= next_beat.due_time;
                    i_now_time <= next_beat.now_time;
                    send_valid = 1'b1;
                end
            end
            i_valid <= send_valid;
        end
    end

    // Receiver: stall each result for a random number of cycles
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (reply_taken) begin
                reply_taken = 1'b0;
                stall_left  = quiet_out ? 0 : $urandom_range(0, 4);
                if ($urandom_range(0, 59) == 0) quiet_out = !quiet_out;
            end else if (stall_left > 0 && reply_seen) begin
                stall_left--;
            end
            i_stall <= (stall_left > 0);
        end
    end

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                     $time, what, want, want, got, got);
        end
    endtask

    // Monitor: record accepted beats and check result beats on the rising edge
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n) begin
            reply_seen = o_valid && i_stall;
            if (i_valid && !o_stall) begin
                pending_replies.push_back(apply_timer_op(t_op'(i_opcode), i_event_id,
                                                         i_due_time, i_now_time));
                beat_taken = 1'b1;
            end
            if (o_valid && !i_stall) begin
                reply_taken = 1'b1;
                if (pending_replies.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with none expected, status %0d id 0x%0h",
                             $time, o_status, o_popped_id);
                end else begin
                    want = pending_replies.pop_front();
                    check_field("status",        want.status,  o_status);
                    check_field("removed_count", want.removed, o_removed_count);
                    check_field("popped_id",     want.id,      o_popped_id);
                    check_field("popped_due",    want.due,     o_popped_due);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycle_count, pending_replies.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

FILE: sorted_timer_event_queue.f
src/steq_pkg.sv
src/steq_ctrl.sv
src/steq_dpath.sv
src/sorted_timer_event_queue.sv
tb/tb_sorted_timer_event_queue.sv
